FILE: hdl/edf_tick_scheduler_defines.svh
// ----------------------------------------------------------------------------
// edf tick scheduler assertion macros
// shared property wrappers used by the scheduler controller
// ----------------------------------------------------------------------------
`ifndef EDF_TICK_SCHEDULER_DEFINES_SVH
`define EDF_TICK_SCHEDULER_DEFINES_SVH

// implication that must hold every cycle outside reset
`define EDF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf scheduler package
// shared types, constants and command structs
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int MAX_JOBS_DEF  = 16;
    localparam int TICK_STEP_DEF = 1;

    localparam int FIELD_W = 16;
    localparam int TICK_W  = 32;
    localparam int DL_W    = 33;
    localparam int TID_W   = 3;

    // datapath commands issued by the controller
    typedef struct packed {
        logic load;        // write task descriptor from input word
        logic capture;     // latch input word
        logic rel_start;   // begin modulo check of current task
        logic rel_queue;   // queue job of current task if releasing
        logic task_clr;    // reset task pointer and overflow flag
        logic task_inc;    // step task pointer
        logic scan_clr;    // reset job pointer and clear the best-found flag
        logic scan_step;   // compare job at pointer with best
        logic commit;      // run the chosen job, build result, advance tick
    } edf_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic task_last;
        logic rem_busy;
        logic scan_last;
    } edf_stat_t;

endpackage

FILE: hdl/edf_modulo.sv
// ----------------------------------------------------------------------------
// edf modulo unit
// restoring remainder of a 32-bit dividend by a 16-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module edf_modulo
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] remainder
);
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [16:0] rem_reg;
    logic [16:0] rem_next;
    logic [15:0] div_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [16:0] shifted;
    logic [17:0] diff;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg[15:0], quo_reg[31]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        quo_next = {quo_reg[30:0], 1'b0};
        rem_next = diff[17] ? shifted : diff[16:0];
        cnt_next = cnt_reg - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg[15:0];
endmodule

FILE: hdl/edf_datapath.sv
// ----------------------------------------------------------------------------
// edf datapath
// task table, job store, release check and sequential min-deadline scan
// ----------------------------------------------------------------------------
module edf_datapath
#(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int MAX_JOBS  = edf_pkg::MAX_JOBS_DEF,
    parameter int TICK_STEP = edf_pkg::TICK_STEP_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  edf_pkg::edf_cmd_t     cmd,
    output edf_pkg::edf_stat_t    stat,
    input  logic [2:0]            task_index,
    input  logic                  task_enable,
    input  logic [15:0]           period,
    input  logic [15:0]           first_release,
    input  logic [15:0]           relative_deadline,
    input  logic [15:0]           exec_time,
    output logic [31:0]           tick_value,
    output logic                  idle,
    output logic [2:0]            running_task,
    output logic                  job_done,
    output logic                  overflow
);
    import edf_pkg::*;

    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int JW = $clog2(MAX_JOBS);

    // task table
    logic [FIELD_W-1:0] t_per   [NUM_TASKS];
    logic [FIELD_W-1:0] t_rel   [NUM_TASKS];
    logic [FIELD_W-1:0] t_dl    [NUM_TASKS];
    logic [FIELD_W-1:0] t_work  [NUM_TASKS];
    logic [NUM_TASKS-1:0] t_act_reg;

    // job store
    logic [MAX_JOBS-1:0] j_val_reg;
    logic [TID_W-1:0]    j_task [MAX_JOBS];
    logic [DL_W-1:0]     j_dl   [MAX_JOBS];
    logic [FIELD_W-1:0]  j_rem  [MAX_JOBS];
    logic [TICK_W-1:0]   j_age  [MAX_JOBS];

    logic [TICK_W-1:0] tick_reg;
    logic [TW-1:0]     tptr_reg;
    logic [JW-1:0]     jptr_reg;
    logic [JW-1:0]     best_reg;
    logic              found_reg;
    logic              ovf_reg;

    logic [2:0]  idx_reg;
    logic        en_reg;
    logic [15:0] per_reg, fr_reg, rd_reg, ex_reg;

    logic        mod_busy;
    logic [15:0] mod_rem;
    logic [31:0] diff;
    logic        ge;
    logic        rel_hit;
    logic        free_any;
    logic [JW-1:0] free_slot;
    logic        better;

    // capture load/tick word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= task_index;
            en_reg  <= task_enable;
            per_reg <= period;
            fr_reg  <= first_release;
            rd_reg  <= relative_deadline;
            ex_reg  <= exec_time;
        end
    end

    // release test operands
    assign ge   = tick_reg >= {16'd0, t_rel[tptr_reg]};
    assign diff = tick_reg - {16'd0, t_rel[tptr_reg]};

    edf_modulo u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rel_start),
        .dividend  (diff),
        .divisor   (t_per[tptr_reg]),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_comb
    begin
        if (t_per[tptr_reg] == '0)
            rel_hit = t_act_reg[tptr_reg] && ge && (diff == '0);
        else
            rel_hit = t_act_reg[tptr_reg] && ge && (mod_rem == '0);
    end

    // lowest free job slot
    always_comb
    begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int j = MAX_JOBS - 1; j >= 0; j--)
        begin
            if (!j_val_reg[j])
            begin
                free_any  = 1'b1;
                free_slot = JW'(j);
            end
        end
    end

    // scan compare
    always_comb
    begin
        better = j_val_reg[jptr_reg] &&
                 (!found_reg ||
                  (j_dl[jptr_reg] < j_dl[best_reg]) ||
                  ((j_dl[jptr_reg] == j_dl[best_reg]) &&
                   (j_age[jptr_reg] > j_age[best_reg])));
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_act_reg <= '0;
            j_val_reg <= '0;
            tick_reg  <= '0;
            tptr_reg  <= '0;
            jptr_reg  <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load && (int'(idx_reg) < NUM_TASKS))
                t_act_reg[TW'(idx_reg)] <= en_reg;
            if (cmd.task_clr)
            begin
                tptr_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (cmd.task_inc)
                tptr_reg <= tptr_reg + TW'(1);
            if (cmd.rel_queue && rel_hit)
            begin
                if (free_any)
                    j_val_reg[free_slot] <= 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.scan_clr)
            begin
                jptr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                jptr_reg <= jptr_reg + JW'(1);
                if (better)
                begin
                    best_reg  <= jptr_reg;
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                tick_reg <= tick_reg + TICK_W'(TICK_STEP);
                if (found_reg && (j_rem[best_reg] <= 16'd1))
                    j_val_reg[best_reg] <= 1'b0;
            end
        end
    end

    // payload stores
    always_ff @(posedge clk)
    begin
        if (cmd.load && (int'(idx_reg) < NUM_TASKS))
        begin
            t_per[TW'(idx_reg)]  <= per_reg;
            t_rel[TW'(idx_reg)]  <= fr_reg;
            t_dl[TW'(idx_reg)]   <= rd_reg;
            t_work[TW'(idx_reg)] <= ex_reg;
        end
        if (cmd.rel_queue && rel_hit && free_any)
        begin
            for (int j = 0; j < MAX_JOBS; j++)
            begin
                if (j_val_reg[j] && (j_age[j] != '1))
                    j_age[j] <= j_age[j] + 32'd1;
            end
            j_task[free_slot] <= TID_W'(tptr_reg);
            j_dl[free_slot]   <= {1'b0, tick_reg} + {17'd0, t_dl[tptr_reg]};
            j_rem[free_slot]  <= t_work[tptr_reg];
            j_age[free_slot]  <= '0;
        end
        if (cmd.commit && found_reg)
        begin
            if (j_rem[best_reg] <= 16'd1)
                j_rem[best_reg] <= '0;
            else
                j_rem[best_reg] <= j_rem[best_reg] - 16'd1;
        end
        if (cmd.commit)
        begin
            tick_value   <= tick_reg;
            idle         <= !found_reg;
            running_task <= found_reg ? j_task[best_reg] : '0;
            job_done     <= found_reg && (j_rem[best_reg] <= 16'd1);
            overflow     <= ovf_reg;
        end
    end

    assign stat.task_last = (tptr_reg == TW'(NUM_TASKS - 1));
    assign stat.rem_busy  = mod_busy;
    assign stat.scan_last = (jptr_reg == JW'(MAX_JOBS - 1));
endmodule

FILE: hdl/edf_ctrl.sv
// ----------------------------------------------------------------------------
// edf controller
// sequences load, release pass, scan pass and result handoff
// ----------------------------------------------------------------------------
module edf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    output logic                 out_valid,
    input  logic                 out_stall,
    output edf_pkg::edf_cmd_t    cmd,
    input  edf_pkg::edf_stat_t   stat
);
    import edf_pkg::*;
`include "edf_tick_scheduler_defines.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_RSTRT = 3'd2;
    localparam logic [2:0] ST_RWAIT = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_COMM  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       accept;

    // output register free once taken or empty
    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    cmd.task_clr = !mode;
                    state_next  = mode ? ST_LOAD : ST_RSTRT;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RSTRT:
            begin
                cmd.rel_start = 1'b1;
                state_next    = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (!stat.rem_busy)
                begin
                    cmd.rel_queue = 1'b1;
                    if (stat.task_last)
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        cmd.task_inc = 1'b1;
                        state_next   = ST_RSTRT;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = ST_COMM;
            end
            ST_COMM:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    `EDF_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !accept,
        "word accepted while busy")
    `EDF_ASSERT_IMPL(a_commit_free, clk, rst_n, cmd.commit, !(ov_reg && out_stall),
        "result overwritten while stalled")
    `EDF_ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid,
        "commit without result")
endmodule

FILE: hdl/edf_tick_scheduler.sv
// ----------------------------------------------------------------------------
// edf tick scheduler
// periodic-task earliest-deadline-first scheduler, top level
// ----------------------------------------------------------------------------
// A tick word runs a release pass and a scan pass: each task's release test runs
// through a shared bit-serial remainder unit plus a queue step, then the job
// store is scanned one slot a cycle for the earliest deadline. One result word
// follows each tick word and is held in an output register.
module edf_tick_scheduler
#(
    parameter int NUM_TASKS = edf_pkg::NUM_TASKS_DEF,
    parameter int MAX_JOBS  = edf_pkg::MAX_JOBS_DEF,
    parameter int TICK_STEP = edf_pkg::TICK_STEP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [2:0]  task_index,
    input  logic        task_enable,
    input  logic [15:0] period,
    input  logic [15:0] first_release,
    input  logic [15:0] relative_deadline,
    input  logic [15:0] exec_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tick_value,
    output logic        idle,
    output logic [2:0]  running_task,
    output logic        job_done,
    output logic        overflow
);
    import edf_pkg::*;

    edf_cmd_t  cmd;
    edf_stat_t stat;

    edf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    edf_datapath
    #(
        .NUM_TASKS (NUM_TASKS),
        .MAX_JOBS  (MAX_JOBS),
        .TICK_STEP (TICK_STEP)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .task_index        (task_index),
        .task_enable       (task_enable),
        .period            (period),
        .first_release     (first_release),
        .relative_deadline (relative_deadline),
        .exec_time         (exec_time),
        .tick_value        (tick_value),
        .idle              (idle),
        .running_task      (running_task),
        .job_done          (job_done),
        .overflow          (overflow)
    );
endmodule

FILE: verif/tb_edf_tick_scheduler.sv
// ----------------------------------------------------------------------------
// edf tick scheduler testbench
// drives load and tick words through the valid/stall channels, predicts each
// scheduling decision with an in-bench earliest-deadline-first model and
// compares every result word field by field, with random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_edf_tick_scheduler;

    localparam int N_TASKS   = edf_pkg::NUM_TASKS_DEF;
    localparam int N_JOBS    = edf_pkg::MAX_JOBS_DEF;
    localparam int STEP      = edf_pkg::TICK_STEP_DEF;
    localparam int N_RANDOM  = 925;
    localparam int CALM_TAIL = 100;
    localparam int DRAIN_CYC = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct {
        logic [31:0] tick;
        logic        idle;
        logic [2:0]  task_id;
        logic        done;
        logic        ovf;
    } sched_word_t;

    typedef struct {
        logic        mode;
        logic [2:0]  idx;
        logic        en;
        logic [15:0] per;
        logic [15:0] rel;
        logic [15:0] dl;
        logic [15:0] ex;
        bit          typed;
        sched_word_t want;
    } cmd_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [2:0]  task_index;
    logic        task_enable;
    logic [15:0] period;
    logic [15:0] first_release;
    logic [15:0] relative_deadline;
    logic [15:0] exec_time;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] tick_value;
    logic        idle;
    logic [2:0]  running_task;
    logic        job_done;
    logic        overflow;

    edf_tick_scheduler u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .task_index        (task_index),
        .task_enable       (task_enable),
        .period            (period),
        .first_release     (first_release),
        .relative_deadline (relative_deadline),
        .exec_time         (exec_time),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tick_value        (tick_value),
        .idle              (idle),
        .running_task      (running_task),
        .job_done          (job_done),
        .overflow          (overflow)
    );

    // scheduler shadow state
    logic [31:0] sh_tick;
    logic [15:0] sh_period [N_TASKS];
    logic [15:0] sh_release [N_TASKS];
    logic [15:0] sh_deadline [N_TASKS];
    logic [15:0] sh_work [N_TASKS];
    bit          sh_active [N_TASKS];
    bit          jb_valid [N_JOBS];
    logic [2:0]  jb_task [N_JOBS];
    logic [32:0] jb_deadline [N_JOBS];
    logic [15:0] jb_left [N_JOBS];
    logic [31:0] jb_age [N_JOBS];

    sched_word_t pending_words[$];
    int          n_errors;
    bit          calm;
    longint      cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic bit task_releases(input int t);
        logic [31:0] diff;
        if (sh_tick < {16'h0, sh_release[t]})
            return 0;
        diff = sh_tick - {16'h0, sh_release[t]};
        if (sh_period[t] == 16'h0)
            return diff == 32'h0;
        return (diff % {16'h0, sh_period[t]}) == 32'h0;
    endfunction

    // put a job of task t in the lowest free slot, aging the others
    function automatic bit enqueue_job(input int t);
        int slot;
        slot = -1;
        for (int j = 0; j < N_JOBS; j++)
            if (!jb_valid[j] && slot < 0)
                slot = j;
        if (slot < 0)
            return 0;
        for (int j = 0; j < N_JOBS; j++)
            if (jb_valid[j] && jb_age[j] != 32'hFFFF_FFFF)
                jb_age[j]++;
        jb_valid[slot]    = 1;
        jb_task[slot]     = t[2:0];
        jb_deadline[slot] = {1'b0, sh_tick} + {17'h0, sh_deadline[t]};
        jb_left[slot]     = sh_work[t];
        jb_age[slot]      = 32'h0;
        return 1;
    endfunction

    // one scheduling tick: release, pick earliest deadline, run one quantum
    function automatic sched_word_t edf_decide();
        sched_word_t w;
        int best;
        best  = -1;
        w.ovf = 1'b0;
        for (int t = 0; t < N_TASKS; t++)
            if (sh_active[t] && task_releases(t))
                if (!enqueue_job(t))
                    w.ovf = 1'b1;
        for (int j = 0; j < N_JOBS; j++)
        begin
            if (!jb_valid[j])
                continue;
            if (best < 0 || jb_deadline[j] < jb_deadline[best] ||
                (jb_deadline[j] == jb_deadline[best] && jb_age[j] > jb_age[best]))
                best = j;
        end
        w.tick = sh_tick;
        if (best < 0)
        begin
            w.idle    = 1'b1;
            w.task_id = 3'd0;
            w.done    = 1'b0;
        end
        else
        begin
            w.idle    = 1'b0;
            w.task_id = jb_task[best];
            w.done    = 1'b0;
            if (jb_left[best] <= 16'd1)
            begin
                jb_left[best]  = 16'd0;
                jb_valid[best] = 0;
                w.done         = 1'b1;
            end
            else
                jb_left[best]--;
        end
        sh_tick = sh_tick + STEP;
        return w;
    endfunction

    // apply an accepted word to the shadow state
    function automatic void absorb_word(input cmd_word_t c);
        sched_word_t w;
        if (c.mode == MODE_LOAD)
        begin
            sh_active[c.idx]   = c.en;
            sh_period[c.idx]   = c.per;
            sh_release[c.idx]  = c.rel;
            sh_deadline[c.idx] = c.dl;
            sh_work[c.idx]     = c.ex;
        end
        else
        begin
            w = edf_decide();
            if (c.typed)
                w = c.want;
            pending_words.insert(pending_words.size(), w);
        end
    endfunction

    // send one word, with an optional random gap in front
    task automatic send_word(input cmd_word_t c);
        bit taken;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        mode              <= c.mode;
        task_index        <= c.idx;
        task_enable       <= c.en;
        period            <= c.per;
        first_release     <= c.rel;
        relative_deadline <= c.dl;
        exec_time         <= c.ex;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        absorb_word(c);
    endtask

    function automatic cmd_word_t load_word(input int idx, input bit en, input int per,
                                            input int rel, input int dl, input int ex);
        cmd_word_t c;
        c.mode  = MODE_LOAD;
        c.idx   = idx[2:0];
        c.en    = en;
        c.per   = per[15:0];
        c.rel   = rel[15:0];
        c.dl    = dl[15:0];
        c.ex    = ex[15:0];
        c.typed = 0;
        c.want  = '{default: '0};
        return c;
    endfunction

    function automatic cmd_word_t tick_word();
        cmd_word_t c;
        c = load_word($urandom_range(0, 7), $urandom_range(0, 1), $urandom,
                      $urandom, $urandom, $urandom);
        c.mode = MODE_TICK;
        return c;
    endfunction

    // random descriptor shaped by a load profile
    function automatic cmd_word_t random_load(input int profile);
        int per;
        int ex;
        int dl;
        int rel;
        bit en;
        rel = sh_tick[15:0] + $urandom_range(0, 12);
        en  = $urandom_range(0, 5) != 0;
        case (profile)
            0:
            begin
                per = $urandom_range(4, 24);
                ex  = $urandom_range(1, 3);
                dl  = $urandom_range(1, 24);
            end
            1:
            begin
                per = $urandom_range(1, 3);
                ex  = $urandom_range(1, 6);
                dl  = $urandom_range(1, 12);
            end
            2:
            begin
                per = $urandom_range(2, 40);
                ex  = $urandom_range(1, 4);
                dl  = $urandom_range(1, 40);
                en  = $urandom_range(0, 2) == 0;
            end
            default:
            begin
                per = $urandom_range(1, 65535);
                dl  = $urandom_range(1, 65535);
                ex  = $urandom_range(0, 7) == 0 ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 5);
                rel = $urandom_range(0, 1) ? $urandom_range(0, 65535) : rel;
                if ($urandom_range(0, 1))
                    per = $urandom_range(1, 6);
            end
        endcase
        return load_word($urandom_range(0, 7), en, per, rel, dl, ex);
    endfunction

    // result checker: a word is taken at the edge after a negedge with
    // valid high and stall low
    initial
    begin
        sched_word_t exp_w;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    exp_w = pending_words.pop_front();
                    if (tick_value !== exp_w.tick)
                        report_mismatch($sformatf("tick_value %0d, expected %0d",
                                                  tick_value, exp_w.tick));
                    if (idle !== exp_w.idle)
                        report_mismatch($sformatf("idle %b, expected %b at tick %0d",
                                                  idle, exp_w.idle, exp_w.tick));
                    if (running_task !== exp_w.task_id)
                        report_mismatch($sformatf("running_task %0d, expected %0d at tick %0d",
                                                  running_task, exp_w.task_id, exp_w.tick));
                    if (job_done !== exp_w.done)
                        report_mismatch($sformatf("job_done %b, expected %b at tick %0d",
                                                  job_done, exp_w.done, exp_w.tick));
                    if (overflow !== exp_w.ovf)
                        report_mismatch($sformatf("overflow %b, expected %b at tick %0d",
                                                  overflow, exp_w.ovf, exp_w.tick));
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        int len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                len = $urandom_range(1, 16);
                out_stall <= $urandom_range(0, 2) == 0;
                repeat (len) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin
        cmd_word_t plan[$];
        cmd_word_t c;
        int sent;
        int profile;
        int burst;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        mode              = MODE_TICK;
        task_index        = 3'd0;
        task_enable       = 1'b0;
        period            = 16'd0;
        first_release     = 16'd0;
        relative_deadline = 16'd0;
        exec_time         = 16'd0;
        calm              = 0;
        n_errors          = 0;
        cycles            = 0;
        sh_tick           = 32'h0;
        for (int t = 0; t < N_TASKS; t++)
            sh_active[t] = 0;
        for (int j = 0; j < N_JOBS; j++)
            jb_valid[j] = 0;

        // directed table
        c = tick_word();
        c.typed = 1;
        c.want  = '{tick: 32'd0, idle: 1'b1, task_id: 3'd0, done: 1'b0, ovf: 1'b0};
        plan.insert(plan.size(), c);
        // zero period and zero work: one release at tick 3, done on first quantum
        plan.insert(plan.size(), load_word(7, 1, 0, 3, 65535, 0));
        // extreme descriptor: one long job with a far deadline
        plan.insert(plan.size(), load_word(0, 1, 65535, 2, 65535, 65535));
        // inactive slot with all bits set
        plan.insert(plan.size(), load_word(2, 0, 65535, 65535, 65535, 65535));
        plan.insert(plan.size(), load_word(1, 1, 2, 1, 2, 1));
        // equal deadlines: the older job goes first
        plan.insert(plan.size(), load_word(4, 1, 4, 3, 10, 2));
        plan.insert(plan.size(), load_word(5, 1, 4, 3, 10, 2));
        plan.insert(plan.size(), load_word(6, 1, 1, 4, 1, 1));
        for (int i = 0; i < 12; i++)
            plan.insert(plan.size(), tick_word());
        // reload leaves queued jobs alone
        plan.insert(plan.size(), load_word(4, 0, 1, 0, 1, 1));
        plan.insert(plan.size(), load_word(6, 0, 1, 0, 1, 1));
        plan.insert(plan.size(), load_word(1, 0, 1, 0, 1, 1));
        for (int i = 0; i < 4; i++)
            plan.insert(plan.size(), tick_word());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i]);

        // random phases: a set of loads, then mostly ticks
        sent = 0;
        while (sent < N_RANDOM)
        begin
            profile = $urandom_range(0, 3);
            burst   = $urandom_range(2, 8);
            for (int i = 0; i < burst && sent < N_RANDOM; i++)
            begin
                calm = sent >= N_RANDOM - CALM_TAIL;
                send_word(random_load(profile));
                sent++;
            end
            burst = $urandom_range(20, 60);
            for (int i = 0; i < burst && sent < N_RANDOM; i++)
            begin
                calm = sent >= N_RANDOM - CALM_TAIL;
                send_word($urandom_range(0, 11) == 0 ? random_load(profile) : tick_word());
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
